@@ design/lruhc_pkg.sv @@
`timescale 1ns / 1ps

package lruhc_pkg;

    localparam int MAX_ENTRIES_DEF = 32;

    localparam int KEY_W      = 64;
    localparam int SIZE_W     = 6;
    localparam int SIZE_CMP_W = SIZE_W + 1;
    localparam int COST_W     = 3;
    localparam int TOTAL_W    = 24;

    localparam logic [COST_W-1:0]  COST_HIT       = 3'd1;
    localparam logic [COST_W-1:0]  COST_MISS      = 3'd5;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX      = 24'hFFFFFF;
    localparam logic [SIZE_W-1:0]  CACHE_SIZE_RST = 6'd32;

    typedef enum logic [1:0] {
        CTL_IDLE,
        CTL_MATCH,
        CTL_UPDATE
    } ctl_state_t;

    typedef struct packed {
        logic load_key;
        logic match;
        logic commit;
    } dp_cmd_t;

    typedef struct packed {
        logic out_valid;
    } dp_status_t;

    function automatic logic [KEY_W-1:0] fold_key(input logic [KEY_W-1:0] k);
        logic [KEY_W-1:0] r;
        logic [7:0]       c;
        r = '0;
        for (int b = 0; b < KEY_W / 8; b++) begin
            c = k[8*b +: 8];
            if (c >= 8'h41 && c <= 8'h5A) begin
                c = c + 8'h20;
            end
            r[8*b +: 8] = c;
        end
        return r;
    endfunction

endpackage

@@ design/lruhc_ctrl.sv @@
`timescale 1ns / 1ps

module lruhc_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  m_ready,
    input  lruhc_pkg::dp_status_t status,
    output lruhc_pkg::dp_cmd_t    cmd
);

    lruhc_pkg::ctl_state_t state_reg;
    lruhc_pkg::ctl_state_t state_next;

    logic out_free;

    assign out_free = !status.out_valid || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= lruhc_pkg::CTL_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        s_ready      = 1'b0;
        cmd.load_key = 1'b0;
        cmd.match    = 1'b0;
        cmd.commit   = 1'b0;
        case (state_reg)
            lruhc_pkg::CTL_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_key = 1'b1;
                    state_next   = lruhc_pkg::CTL_MATCH;
                end
            end
            lruhc_pkg::CTL_MATCH: begin
                cmd.match  = 1'b1;
                state_next = lruhc_pkg::CTL_UPDATE;
            end
            lruhc_pkg::CTL_UPDATE: begin
                if (out_free) begin
                    cmd.commit = 1'b1;
                    s_ready    = 1'b1;
                    if (s_valid) begin
                        cmd.load_key = 1'b1;
                        state_next   = lruhc_pkg::CTL_MATCH;
                    end else begin
                        state_next = lruhc_pkg::CTL_IDLE;
                    end
                end
            end
            default: begin
                state_next = lruhc_pkg::CTL_IDLE;
            end
        endcase
    end

endmodule

@@ design/lruhc_datapath.sv @@
`timescale 1ns / 1ps

module lruhc_datapath #(
    parameter int MAX_ENTRIES = lruhc_pkg::MAX_ENTRIES_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  lruhc_pkg::dp_cmd_t                 cmd,
    output lruhc_pkg::dp_status_t              status,
    input  logic [lruhc_pkg::KEY_W-1:0]        s_city_key,
    input  logic                               cfg_valid,
    input  logic [lruhc_pkg::SIZE_W-1:0]       cfg_data,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic                               m_hit,
    output logic [lruhc_pkg::COST_W-1:0]       m_access_cost,
    output logic [lruhc_pkg::TOTAL_W-1:0]      m_total_cost
);

    localparam int RW   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW   = $clog2(MAX_ENTRIES + 1);
    localparam int CMPW = lruhc_pkg::SIZE_CMP_W;
    localparam int TW   = lruhc_pkg::TOTAL_W;

    logic [lruhc_pkg::KEY_W-1:0] tag_reg [MAX_ENTRIES];
    logic [RW-1:0]               rank_reg [MAX_ENTRIES];
    logic [CW-1:0]               occ_reg;
    logic [TW-1:0]               total_reg;
    logic [lruhc_pkg::SIZE_W-1:0] cache_size_reg;
    logic [lruhc_pkg::KEY_W-1:0] key_reg;
    logic [MAX_ENTRIES-1:0]      hit_vec_reg;
    logic [MAX_ENTRIES-1:0]      old_vec_reg;

    logic                        m_valid_reg;
    logic                        m_hit_reg;
    logic [lruhc_pkg::COST_W-1:0] m_cost_reg;
    logic [TW-1:0]               m_total_reg;

    logic [MAX_ENTRIES-1:0]      hit_vec_next;
    logic [MAX_ENTRIES-1:0]      old_vec_next;
    logic [RW-1:0]               oldest_rank;

    logic [CMPW-1:0]             size_eff;
    logic                        active;
    logic                        hit;
    logic                        do_insert;
    logic                        do_evict;
    logic [MAX_ENTRIES-1:0]      sel_vec;
    logic [RW-1:0]               sel_rank;
    logic [lruhc_pkg::COST_W-1:0] cost;
    logic [TW:0]                 sum;
    logic [TW-1:0]               total_next;

    // search
    assign oldest_rank = RW'(occ_reg - CW'(1));

    always_comb begin
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            hit_vec_next[i] = (CW'(i) < occ_reg) && (tag_reg[i] == key_reg);
            old_vec_next[i] = (CW'(i) < occ_reg) && (rank_reg[i] == oldest_rank);
        end
    end

    // replacement decision
    assign size_eff  = ({1'b0, cache_size_reg} > CMPW'(MAX_ENTRIES)) ? CMPW'(MAX_ENTRIES)
                                                                     : {1'b0, cache_size_reg};
    assign active    = (size_eff != '0);
    assign hit       = active && (|hit_vec_reg);
    assign do_insert = active && !hit && (CMPW'(occ_reg) < size_eff);
    assign do_evict  = active && !hit && !do_insert;

    always_comb begin
        sel_rank = '0;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            if (hit) begin
                sel_vec[i] = hit_vec_reg[i];
            end else if (do_insert) begin
                sel_vec[i] = (CW'(i) == occ_reg);
            end else begin
                sel_vec[i] = old_vec_reg[i];
            end
            sel_rank = sel_rank | (sel_vec[i] ? rank_reg[i] : '0);
        end
    end

    assign cost       = hit ? lruhc_pkg::COST_HIT : lruhc_pkg::COST_MISS;
    assign sum        = {1'b0, total_reg} + (TW + 1)'(cost);
    assign total_next = sum[TW] ? lruhc_pkg::TOTAL_MAX : sum[TW-1:0];

    always_ff @(posedge aclk) begin
        if (cmd.load_key) begin
            key_reg <= lruhc_pkg::fold_key(s_city_key);
        end
        if (cmd.match) begin
            hit_vec_reg <= hit_vec_next;
            old_vec_reg <= old_vec_next;
        end
        if (cmd.commit && (do_insert || do_evict)) begin
            for (int i = 0; i < MAX_ENTRIES; i++) begin
                if (sel_vec[i]) begin
                    tag_reg[i] <= key_reg;
                end
            end
        end
        if (cmd.commit) begin
            m_hit_reg   <= hit;
            m_cost_reg  <= cost;
            m_total_reg <= total_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < MAX_ENTRIES; i++) begin
                rank_reg[i] <= '0;
            end
            occ_reg        <= '0;
            total_reg      <= '0;
            cache_size_reg <= lruhc_pkg::CACHE_SIZE_RST;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_valid) begin
                cache_size_reg <= cfg_data;
            end
            if (cmd.commit) begin
                total_reg <= total_next;
                if (active) begin
                    for (int i = 0; i < MAX_ENTRIES; i++) begin
                        if (sel_vec[i]) begin
                            rank_reg[i] <= '0;
                        end else if ((CW'(i) < occ_reg) && (do_insert || rank_reg[i] < sel_rank)) begin
                            rank_reg[i] <= rank_reg[i] + RW'(1);
                        end
                    end
                end
                if (do_insert) begin
                    occ_reg <= occ_reg + CW'(1);
                end
            end
            if (cmd.commit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign status.out_valid = m_valid_reg;
    assign m_valid          = m_valid_reg;
    assign m_hit            = m_hit_reg;
    assign m_access_cost    = m_cost_reg;
    assign m_total_cost     = m_total_reg;

    a_occ_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        CMPW'(occ_reg) <= CMPW'(MAX_ENTRIES))
        else $error("occupancy above capacity");

    a_tags_unique: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |-> $onehot0(hit_vec_reg))
        else $error("key matched more than one entry");

    a_victim_unique: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.commit && do_evict) |-> $onehot(old_vec_reg))
        else $error("no single least recent entry");

    a_total_monotonic: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |=> (total_reg >= $past(total_reg)) && m_valid_reg)
        else $error("running total fell or result lost");

    a_cost_match: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_hit_reg ? (m_cost_reg == lruhc_pkg::COST_HIT)
                                   : (m_cost_reg == lruhc_pkg::COST_MISS)))
        else $error("cost disagrees with hit");

endmodule

@@ design/lru_cache_hit_cost_counter_top.sv @@
`timescale 1ns / 1ps

// channel   handshake           word
// s_        s_valid / s_ready   s_city_key[63:0]
// m_        m_valid / m_ready   m_hit, m_access_cost[2:0], m_total_cost[23:0]
// cfg_      cfg_valid/cfg_ready cfg_data[5:0] (cache_size)
//
// an item passes the parallel tag and age compare, then the replacement and age
// update, both against the register-based tag store
// a new word is taken in the update cycle when the output register is free
// a result waits in the output register while m_ready is low; the update then holds
// aresetn is synchronous: store empty, ages and total zero, cache_size 32

module lru_cache_hit_cost_counter_top #(
    parameter int MAX_ENTRIES = lruhc_pkg::MAX_ENTRIES_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [lruhc_pkg::KEY_W-1:0]      s_city_key,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic                             m_hit,
    output logic [lruhc_pkg::COST_W-1:0]     m_access_cost,
    output logic [lruhc_pkg::TOTAL_W-1:0]    m_total_cost,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [lruhc_pkg::SIZE_W-1:0]     cfg_data
);

    lruhc_pkg::dp_cmd_t    cmd;
    lruhc_pkg::dp_status_t status;

    assign cfg_ready = 1'b1;

    lruhc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    lruhc_datapath #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .status        (status),
        .s_city_key    (s_city_key),
        .cfg_valid     (cfg_valid),
        .cfg_data      (cfg_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_hit         (m_hit),
        .m_access_cost (m_access_cost),
        .m_total_cost  (m_total_cost)
    );

endmodule
